[rtl/core/gfs_pkg.sv]
package gfs_pkg;

    localparam int TRAIT_W = 16;
    localparam int FIT_W   = 17;
    localparam int CNT_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_00 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_01 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_10 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_11 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OPT_0   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OPT_1   = 3'd5;

    // Exponent limit: q at or above this gives zero fitness.
    localparam logic signed [63:0] Q_LIMIT = 64'sd402653184;
    localparam logic [32:0] ONE_Q31 = 33'h080000000;

    typedef struct packed {
        logic signed [15:0] g00;
        logic signed [15:0] g01;
        logic signed [15:0] g10;
        logic signed [15:0] g11;
        logic signed [15:0] opt0;
        logic signed [15:0] opt1;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] trait0;
        logic signed [15:0] trait1;
        logic [15:0]        draw;
        logic               last;
    } item_t;

    typedef struct packed {
        logic               survives;
        logic [FIT_W-1:0]   fitness;
        logic [CNT_W-1:0]   slot;
        logic [CNT_W-1:0]   total;
    } result_t;

endpackage

[rtl/core/gfs_stream_if.sv]
interface gfs_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/gaussian_fitness_selection.sv]
// One individual is processed at a time: after a transfer on the input channel the block
// stays busy while a sequencer runs every multiply of the quadratic form, the powers of the
// exp series and eight squarings through one shared multiplier; the series is skipped when
// fitness saturates at 1.0 or 0, and the second trait's steps with a single trait. The
// result then sits in an output register and the next item can be taken the cycle after; a
// result that still waits in that register holds the block busy. Configuration registers
// must be written only while the block is idle; the block itself does not enforce this.
module gaussian_fitness_selection
    import gfs_pkg::*;
#(
    parameter int TRAIT_COUNT    = 2,
    parameter int MAX_POPULATION = 65535
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    gfs_stream_if.sink           in_item,
    gfs_stream_if.source         out_result
);
    cfg_t               cfg_reg;
    logic               busy_reg;
    item_t              item_reg;
    logic [CNT_W-1:0]   cnt_reg;
    result_t            res_reg;
    logic               res_valid_reg;
    logic               done;
    logic [FIT_W-1:0]   fit;
    logic               live;
    logic               start;
    logic               finish;
    logic [CNT_W-1:0]   cnt_inc;
    logic               done_hold;
    logic               live_hold;
    logic [FIT_W-1:0]   fit_hold;

    assign start = in_item.valid && in_item.ready;
    assign in_item.ready = !busy_reg;

    gfs_fitness_unit #(.TRAIT_COUNT(TRAIT_COUNT)) u_fit (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cfg     (cfg_reg),
        .trait0  (in_item.payload.trait0),
        .trait1  (in_item.payload.trait1),
        .done    (done),
        .fitness (fit)
    );

    assign live    = {1'b0, item_reg.draw} < fit;
    assign cnt_inc = (cnt_reg < CNT_W'(MAX_POPULATION)) ? cnt_reg + 1'b1 : cnt_reg;
    // A finished result waits until the output register is free.
    assign finish  = busy_reg && done_hold && !(res_valid_reg && !out_result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '{g00: 16'sd256, g01: 16'sd0, g10: 16'sd0, g11: 16'sd256,
                               opt0: 16'sd0, opt1: 16'sd0};
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN_00: cfg_reg.g00  <= cfg_data;
                    REG_GAIN_01: cfg_reg.g01  <= cfg_data;
                    REG_GAIN_10: cfg_reg.g10  <= cfg_data;
                    REG_GAIN_11: cfg_reg.g11  <= cfg_data;
                    REG_OPT_0:   cfg_reg.opt0 <= cfg_data;
                    REG_OPT_1:   cfg_reg.opt1 <= cfg_data;
                    default: ;
                endcase
            end
            if (finish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_result.valid && out_result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
                if (item_reg.last)
                begin
                    cnt_reg <= '0;
                end
                else if (live_hold)
                begin
                    cnt_reg <= cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_hold <= 1'b0;
        end
        else if (start)
        begin
            done_hold <= 1'b0;
        end
        else if (done)
        begin
            done_hold <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg <= in_item.payload;
        end
        if (done)
        begin
            live_hold <= live;
            fit_hold  <= fit;
        end
        if (finish)
        begin
            res_reg.survives <= live_hold;
            res_reg.fitness  <= fit_hold;
            res_reg.slot     <= live_hold ? cnt_reg : '0;
            res_reg.total    <= live_hold ? cnt_inc : cnt_reg;
        end
    end

    assign out_result.valid   = res_valid_reg;
    assign out_result.payload = res_reg;
endmodule

[rtl/core/gfs_fitness_unit.sv]
module gfs_fitness_unit
    import gfs_pkg::*;
#(
    parameter int TRAIT_COUNT = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cfg_t              cfg,
    input  logic signed [15:0] trait0,
    input  logic signed [15:0] trait1,
    output logic              done,
    output logic [FIT_W-1:0]  fitness
);
    // Sequencer steps; each multiplying step runs one multiply through the shared 33x33 unit.
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_V00  = 5'd1;
    localparam logic [4:0] S_V01  = 5'd2;
    localparam logic [4:0] S_V10  = 5'd3;
    localparam logic [4:0] S_V11  = 5'd4;
    localparam logic [4:0] S_Q0   = 5'd5;
    localparam logic [4:0] S_Q1   = 5'd6;
    localparam logic [4:0] S_CHK  = 5'd7;
    localparam logic [4:0] S_A2   = 5'd8;
    localparam logic [4:0] S_A3   = 5'd9;
    localparam logic [4:0] S_A4   = 5'd10;
    localparam logic [4:0] S_POLY = 5'd11;
    localparam logic [4:0] S_SQ   = 5'd12;
    localparam logic [4:0] S_FIN  = 5'd13;

    // Reciprocals for the series divisions; exact over the operand ranges seen here.
    localparam logic [20:0] RECIP_6  = 21'd1398102;
    localparam logic [16:0] RECIP_24 = 17'd43691;

    logic [4:0]         state_reg, state_next;
    logic [2:0]         sq_reg, sq_next;
    logic signed [16:0] d0_reg, d0_next, d1_reg, d1_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] q_reg, q_next;
    logic [33:0]        a_reg, a_next, a2_reg, a2_next, a3_reg, a3_next, a4_reg, a4_next;
    logic [33:0]        p_reg, p_next;
    logic [FIT_W-1:0]   fit_reg, fit_next;
    logic               done_reg, done_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [63:0]        uprod;
    logic [33:0]        rnd;
    logic [20:0]        a3_adj;
    logic [16:0]        a4_adj;
    logic [41:0]        a3_scaled;
    logic [33:0]        a4_scaled;
    logic [33:0]        poly;

    assign prod      = mul_a * mul_b;
    assign uprod     = prod[63:0];
    assign rnd       = 34'((uprod + 64'h40000000) >> 31);
    assign a3_adj    = 21'(a3_reg + 34'd3);
    assign a4_adj    = 17'(a4_reg + 34'd12);
    assign a3_scaled = a3_adj * RECIP_6;
    assign a4_scaled = a4_adj * RECIP_24;
    assign poly      = 34'(ONE_Q31) - a_reg + ((a2_reg + 34'd1) >> 1)
                       - 34'(a3_scaled >> 23) + 34'(a4_scaled >> 20);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_V00:   begin mul_a = 33'(cfg.g00); mul_b = 33'(d0_reg);  end
            S_V01:   begin mul_a = 33'(cfg.g01); mul_b = 33'(d1_reg);  end
            S_V10:   begin mul_a = 33'(cfg.g10); mul_b = 33'(d0_reg);  end
            S_V11:   begin mul_a = 33'(cfg.g11); mul_b = 33'(d1_reg);  end
            S_Q0:    begin mul_a = 33'(d0_reg);  mul_b = 33'(acc_reg); end
            S_Q1:    begin mul_a = 33'(d1_reg);  mul_b = 33'(acc_reg); end
            S_A2:    begin mul_a = 33'(a_reg);   mul_b = 33'(a_reg);   end
            S_A3:    begin mul_a = 33'(a2_reg);  mul_b = 33'(a_reg);   end
            S_A4:    begin mul_a = 33'(a3_reg);  mul_b = 33'(a_reg);   end
            S_SQ:    begin mul_a = 33'(p_reg);   mul_b = 33'(p_reg);   end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        sq_next    = sq_reg;
        d0_next    = d0_reg;
        d1_next    = d1_reg;
        acc_next   = acc_reg;
        q_next     = q_reg;
        a_next     = a_reg;
        a2_next    = a2_reg;
        a3_next    = a3_reg;
        a4_next    = a4_reg;
        p_next     = p_reg;
        fit_next   = fit_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    d0_next = 17'(trait0) - 17'(cfg.opt0);
                    d1_next = (TRAIT_COUNT > 1) ? 17'(trait1) - 17'(cfg.opt1) : 17'sd0;
                    acc_next = '0;
                    q_next = '0;
                    state_next = S_V00;
                end
            end
            S_V00: begin acc_next = 64'(prod); state_next = S_V01; end
            S_V01: begin acc_next = acc_reg + 64'(prod); state_next = S_Q0; end
            S_Q0:
            begin
                // d0 * v0 on the shared unit; v0 always fits in 33 signed bits.
                q_next = 64'(prod);
                state_next = S_V10;
            end
            S_V10: begin acc_next = 64'(prod); state_next = S_V11; end
            S_V11: begin acc_next = acc_reg + 64'(prod); state_next = S_Q1; end
            S_Q1:
            begin
                q_next = q_reg + 64'(prod);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (q_reg <= 0)
                begin
                    fit_next = 17'h10000;
                    state_next = S_FIN;
                end
                else if (q_reg >= Q_LIMIT)
                begin
                    fit_next = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    a_next = 34'((q_reg + 64'sd2) >>> 2);
                    state_next = S_A2;
                end
            end
            S_A2: begin a2_next = rnd; state_next = S_A3; end
            S_A3: begin a3_next = rnd; state_next = S_A4; end
            S_A4: begin a4_next = rnd; state_next = S_POLY; end
            S_POLY: begin p_next = poly; sq_next = '0; state_next = S_SQ; end
            S_SQ:
            begin
                p_next = rnd;
                sq_next = sq_reg + 3'd1;
                if (sq_reg == 3'd7)
                begin
                    fit_next = 17'((34'(rnd) + 34'd16384) >> 15);
                    state_next = S_FIN;
                end
            end
            S_FIN: begin done_next = 1'b1; state_next = S_IDLE; end
            default: state_next = S_IDLE;
        endcase
        if (TRAIT_COUNT < 2 && state_reg == S_V00)
        begin
            state_next = S_Q0;
        end
        if (TRAIT_COUNT < 2 && state_reg == S_Q0)
        begin
            state_next = S_CHK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg  <= sq_next;
        d0_reg  <= d0_next;
        d1_reg  <= d1_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
        a_reg   <= a_next;
        a2_reg  <= a2_next;
        a3_reg  <= a3_next;
        a4_reg  <= a4_next;
        p_reg   <= p_next;
        fit_reg <= fit_next;
    end

    assign done    = done_reg;
    assign fitness = fit_reg;
endmodule

[tb/tb_gaussian_fitness_selection.sv]
`timescale 1ns / 100ps

module tb_gaussian_fitness_selection;
    import gfs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t res;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    gfs_stream_if #(.payload_t(item_t))   item_ch ();
    gfs_stream_if #(.payload_t(result_t)) result_ch ();

    gaussian_fitness_selection u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_item    (item_ch),
        .out_result (result_ch)
    );

    cfg_t        sel_cfg;
    logic [15:0] survivor_count;
    result_t     fitness_q[$];
    dir_row_t    row_q[$];
    int          mismatches;
    bit          no_idle;
    bit          hold_req;

    dir_row_t dir_tbl[12] = '{
        '{'{16'sh0000, 16'sh0000, 16'h0000, 1'b0}, 1'b1, '{1'b1, 17'd65536, 16'd0, 16'd1}},
        '{'{16'sh0000, 16'sh0000, 16'hFFFF, 1'b0}, 1'b1, '{1'b1, 17'd65536, 16'd1, 16'd2}},
        '{'{16'sh8000, 16'sh8000, 16'h0000, 1'b0}, 1'b1, '{1'b0, 17'd0, 16'd0, 16'd2}},
        '{'{16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b1}, 1'b1, '{1'b0, 17'd0, 16'd0, 16'd2}},
        '{'{16'sh0000, 16'sh0000, 16'hFFFF, 1'b0}, 1'b1, '{1'b1, 17'd65536, 16'd0, 16'd1}},
        '{'{16'sh0100, 16'sh0000, 16'h0000, 1'b0}, 1'b0, '{1'b0, 17'd0, 16'd0, 16'd0}},
        '{'{16'sh0000, 16'shFF00, 16'hFFFF, 1'b0}, 1'b0, '{1'b0, 17'd0, 16'd0, 16'd0}},
        '{'{16'sh0080, 16'shFF80, 16'h4000, 1'b0}, 1'b0, '{1'b0, 17'd0, 16'd0, 16'd0}},
        '{'{16'sh04E6, 16'sh0000, 16'h0000, 1'b0}, 1'b0, '{1'b0, 17'd0, 16'd0, 16'd0}},
        '{'{16'sh04E7, 16'sh0000, 16'h0000, 1'b0}, 1'b0, '{1'b0, 17'd0, 16'd0, 16'd0}},
        '{'{16'sh0000, 16'sh04E6, 16'h0000, 1'b1}, 1'b0, '{1'b0, 17'd0, 16'd0, 16'd0}},
        '{'{16'sh8000, 16'sh7FFF, 16'h9B45, 1'b0}, 1'b0, '{1'b0, 17'd0, 16'd0, 16'd0}}
    };

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint unsigned mul_q31(longint unsigned x, longint unsigned y);
        return (x * y + 64'd1073741824) >> 31;
    endfunction

    // exp(-q/2^25) in Q1.16 by a fourth-order series on q/2^33, squared eight times.
    function automatic logic [16:0] gauss_fitness(longint q);
        longint unsigned a;
        longint unsigned a2;
        longint unsigned a3;
        longint unsigned a4;
        longint unsigned p;
        if (q <= 0)
            return 17'd65536;
        if (q >= longint'(Q_LIMIT))
            return 17'd0;
        a  = (unsigned'(q) + 64'd2) >> 2;
        a2 = mul_q31(a, a);
        a3 = mul_q31(a2, a);
        a4 = mul_q31(a3, a);
        p  = 64'd2147483648 - a + ((a2 + 64'd1) >> 1) - (a3 + 64'd3) / 64'd6
             + (a4 + 64'd12) / 64'd24;
        repeat (8) p = mul_q31(p, p);
        return 17'((p + 64'd16384) >> 15);
    endfunction

    function automatic result_t select_individual(item_t it);
        longint  d0;
        longint  d1;
        longint  q;
        result_t r;
        d0 = longint'(it.trait0) - longint'(sel_cfg.opt0);
        d1 = longint'(it.trait1) - longint'(sel_cfg.opt1);
        q  = d0 * (longint'(sel_cfg.g00) * d0 + longint'(sel_cfg.g01) * d1)
             + d1 * (longint'(sel_cfg.g10) * d0 + longint'(sel_cfg.g11) * d1);
        r.fitness  = gauss_fitness(q);
        r.survives = {1'b0, it.draw} < r.fitness;
        r.slot     = '0;
        if (r.survives)
        begin
            r.slot = survivor_count;
            if (survivor_count != COUNT_MAX)
                survivor_count = survivor_count + 16'd1;
        end
        r.total = survivor_count;
        if (it.last)
            survivor_count = '0;
        return r;
    endfunction

    // Check results against the oldest expectation first, then predict the new input.
    always @(posedge clk)
    begin
        result_t  got;
        result_t  want;
        dir_row_t row;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.payload;
                if (fitness_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %p", got);
                end
                else
                begin
                    want = fitness_q.pop_front();
                    if (got.survives !== want.survives || got.fitness !== want.fitness ||
                        got.slot !== want.slot || got.total !== want.total)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at %0t: expected %p, actual %p",
                                     $time, want, got);
                    end
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                want = select_individual(item_ch.payload);
                if (row_q.size() != 0)
                begin
                    row = row_q.pop_front();
                    if (row.typed)
                        want = row.res;
                end
                fitness_q.push_back(want);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    initial
    begin
        int n;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                result_ch.ready <= 1'b1;
            end
            else
            begin
                n = no_idle ? 0 : pick_gap();
                if (n == 0)
                    result_ch.ready <= 1'b1;
                else
                begin
                    result_ch.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                    result_ch.ready <= 1'b1;
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_GAIN_00: sel_cfg.g00 = val;
            REG_GAIN_01: sel_cfg.g01 = val;
            REG_GAIN_10: sel_cfg.g10 = val;
            REG_GAIN_11: sel_cfg.g11 = val;
            REG_OPT_0:   sel_cfg.opt0 = val;
            REG_OPT_1:   sel_cfg.opt1 = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_matrix(logic [15:0] g00, logic [15:0] g01, logic [15:0] g10,
                                logic [15:0] g11, logic [15:0] o0, logic [15:0] o1);
        write_reg(REG_GAIN_00, g00);
        write_reg(REG_GAIN_01, g01);
        write_reg(REG_GAIN_10, g10);
        write_reg(REG_GAIN_11, g11);
        write_reg(REG_OPT_0, o0);
        write_reg(REG_OPT_1, o1);
    endtask

    task automatic send_item(item_t it);
        int gap;
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        do
            @(posedge clk);
        while (!item_ch.ready);
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // The extra edge lets the last input transfer reach the expectation queue.
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (fitness_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Traits mostly near the optimum so that fitness is neither 0 nor 1.
    function automatic item_t random_individual();
        item_t it;
        if ($urandom_range(9) == 0)
        begin
            it.trait0 = 16'($urandom);
            it.trait1 = 16'($urandom);
        end
        else
        begin
            it.trait0 = sel_cfg.opt0 + 16'($signed($urandom_range(1024)) - 512);
            it.trait1 = sel_cfg.opt1 + 16'($signed($urandom_range(1024)) - 512);
        end
        it.draw = 16'($urandom);
        it.last = ($urandom_range(15) == 0);
        return it;
    endfunction

    task automatic random_matrix();
        write_matrix(16'($urandom_range(600)), 16'($signed($urandom_range(256)) - 128),
                     16'($signed($urandom_range(256)) - 128), 16'($urandom_range(600)),
                     16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.payload <= '0;
        sel_cfg         = '{16'sd256, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0};
        survivor_count  = '0;
        mismatches      = 0;
        no_idle         = 1'b0;
        hold_req        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tbl[i])
        begin
            row_q.push_back(dir_tbl[i]);
            send_item(dir_tbl[i].it);
        end
        drain();

        // A selection matrix that is not positive definite gives fitness 1.0.
        write_matrix(16'hFF00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        write_reg(REG_SPARE_6, 16'h1234);
        write_reg(REG_SPARE_7, 16'hFFFF);
        for (int i = 0; i < 4; i++)
            send_item(random_individual());
        drain();
        // Only trait 0 counts, as with a single trait.
        write_matrix(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0040, 16'h0000);
        for (int i = 0; i < 4; i++)
            send_item(random_individual());
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: write_matrix(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
                1: write_matrix(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
                2: write_matrix(16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h7FFF, 16'h8000);
                default: random_matrix();
            endcase
            no_idle = (ph == 4);
            for (int i = 0; i < 122; i++)
            begin
                if (ph == 5 && i == 10)
                    hold_req = 1'b1;
                send_item(random_individual());
            end
            drain();
        end

        write_matrix(16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000);
        for (int i = 0; i < 8; i++)
            send_item(random_individual());
        drain();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #(64'd200_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
